[sv/dtt_pkg.sv]
// Package for the deadline timer table: sizes, command codes, result codes and cell control type.
package dtt_pkg;

  localparam int SLOTS      = 16;
  localparam int IDX_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int RESULT_CAP = 16;
  localparam int CNT_W      = $clog2(RESULT_CAP);
  localparam int ID_W       = 31;
  localparam int DL_W       = 49;
  localparam int NOW_W      = 48;
  localparam int WAIT_W     = 37;
  localparam int MS_W       = 31;

  localparam logic [9:0]        US_PER_MS  = 10'd1000;
  localparam logic [DL_W-1:0]   EMPTY_WAIT = DL_W'(100000) * DL_W'(1000 * 1000);
  localparam logic [ID_W-1:0]   ID_MAX     = '1;

  // command codes
  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_EXPIRE = 2'd2;
  localparam logic [1:0] CMD_QUERY  = 2'd3;

  // result kinds
  localparam logic [2:0] KIND_ADDED   = 3'd0;
  localparam logic [2:0] KIND_FULL    = 3'd1;
  localparam logic [2:0] KIND_REMOVED = 3'd2;
  localparam logic [2:0] KIND_BAD_ID  = 3'd3;
  localparam logic [2:0] KIND_EXPIRED = 3'd4;
  localparam logic [2:0] KIND_NONE    = 3'd5;
  localparam logic [2:0] KIND_WAIT    = 3'd6;

  // per-cell control
  typedef struct packed {
    logic load_new;
    logic load_prev;
    logic clr;
  } cell_ctrl_t;

endpackage

[sv/deadline_timer_table_top.sv]
// Top level of the deadline timer table: command sequencer over a chain of cells.
//
//  channel   signals                                   transaction
//  command   start, busy, cmd, delay_ms, target_id,    start && !busy
//            now_us
//  result    strobe, kind, timer_id, wait_us, last     strobe (one cycle)
//
// Add, remove: a single command state issues the result. Expire: a mark state, then
// a scan with one slot of the cell chain examined per cycle. Query: the minimum
// deadline is found by a scan over the cells, one per cycle, then a result state.
// Reset (rst, synchronous) empties the table and sets the next id to one.
// The receiver cannot stall; busy is low again in the cycle of the last result.
module deadline_timer_table_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  cmd,
  input  logic [dtt_pkg::MS_W-1:0]    delay_ms,
  input  logic [dtt_pkg::ID_W-1:0]    target_id,
  input  logic [dtt_pkg::NOW_W-1:0]   now_us,
  output logic                        strobe,
  output logic [2:0]                  kind,
  output logic [dtt_pkg::ID_W-1:0]    timer_id,
  output logic [dtt_pkg::WAIT_W-1:0]  wait_us,
  output logic                        last
);
  import dtt_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_ADD      = 7'b0000010,
    ST_REMOVE   = 7'b0000100,
    ST_EXP_MARK = 7'b0001000,
    ST_EXP_SCAN = 7'b0010000,
    ST_QRY_SCAN = 7'b0100000,
    ST_QRY_DONE = 7'b1000000
  } state_t;

  state_t              state;
  logic [MS_W-1:0]     delay_r;
  logic [ID_W-1:0]     target_r;
  logic [NOW_W-1:0]    now_r;
  logic [ID_W-1:0]     next_id;
  logic [IDX_W-1:0]    idx;
  logic [CNT_W-1:0]    cnt;
  logic [SLOTS-1:0]    mask;
  logic                best_valid;
  logic [DL_W-1:0]     best_dl;

  logic [SLOTS-1:0]    valid_v;
  logic [SLOTS-1:0]    expired_v;
  logic [SLOTS-1:0]    match_v;
  logic [SLOTS-1:0]    prefix;
  logic [SLOTS-1:0]    above;
  logic [ID_W-1:0]     id_v [SLOTS];
  logic [DL_W-1:0]     dl_v [SLOTS];
  cell_ctrl_t          ctrl_v [SLOTS];
  logic [DL_W-1:0]     new_dl;
  logic [DL_W-1:0]     diff;
  logic                accept;
  logic                full;
  logic                final_hit;

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);
  assign full   = &valid_v;
  assign new_dl = {1'b0, now_r} + (DL_W'(delay_r) * DL_W'(US_PER_MS));
  assign diff   = best_dl - {1'b0, now_r};

  // prefix of valid cells: a cell shifts on add while all above it are full
  always_comb begin
    prefix[0] = 1'b1;
    for (int i = 1; i < SLOTS; i++) begin
      prefix[i] = prefix[i-1] & valid_v[i-1];
    end
  end

  // expired cells past the scan index
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      above[i] = mask[i] && (i > int'(idx));
    end
  end
  assign final_hit = (above == '0) || (cnt == CNT_W'(RESULT_CAP - 1));

  // cell controls
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      ctrl_v[i].load_new  = (state == ST_ADD) && !full && (i == 0);
      ctrl_v[i].load_prev = (state == ST_ADD) && !full && (i != 0) && prefix[i];
      ctrl_v[i].clr       = ((state == ST_REMOVE) && (target_r != '0) && match_v[i]) ||
                            ((state == ST_EXP_SCAN) && (IDX_W'(i) == idx) && mask[i]);
    end
  end

  // chain of cells, newest entry at cell 0
  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    if (g == 0) begin : g_head
      dtt_cell u_cell (
        .clk, .rst, .ctrl(ctrl_v[g]),
        .prev_valid(1'b0), .prev_id('0), .prev_deadline('0),
        .new_id(next_id), .new_deadline(new_dl), .now(now_r), .target(target_r),
        .valid(valid_v[g]), .id(id_v[g]), .deadline(dl_v[g]),
        .expired(expired_v[g]), .match(match_v[g])
      );
    end else begin : g_body
      dtt_cell u_cell (
        .clk, .rst, .ctrl(ctrl_v[g]),
        .prev_valid(valid_v[g-1]), .prev_id(id_v[g-1]), .prev_deadline(dl_v[g-1]),
        .new_id(next_id), .new_deadline(new_dl), .now(now_r), .target(target_r),
        .valid(valid_v[g]), .id(id_v[g]), .deadline(dl_v[g]),
        .expired(expired_v[g]), .match(match_v[g])
      );
    end
  end

  // command latch
  always_ff @(posedge clk) begin
    if (accept) begin
      delay_r  <= delay_ms;
      target_r <= target_id;
      now_r    <= now_us;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      next_id <= ID_W'(1);
      strobe  <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (cmd)
              CMD_ADD:    state <= ST_ADD;
              CMD_REMOVE: state <= ST_REMOVE;
              CMD_EXPIRE: state <= ST_EXP_MARK;
              default:    state <= ST_QRY_SCAN;
            endcase
            idx        <= '0;
            cnt        <= '0;
            best_valid <= 1'b0;
          end
        end
        ST_ADD: begin
          strobe  <= 1'b1;
          wait_us <= '0;
          last    <= 1'b1;
          if (full) begin
            kind     <= KIND_FULL;
            timer_id <= '0;
          end else begin
            kind     <= KIND_ADDED;
            timer_id <= next_id;
            next_id  <= (next_id == ID_MAX) ? ID_W'(1) : next_id + ID_W'(1);
          end
          state <= ST_IDLE;
        end
        ST_REMOVE: begin
          strobe   <= 1'b1;
          kind     <= (target_r == '0) ? KIND_BAD_ID : KIND_REMOVED;
          timer_id <= '0;
          wait_us  <= '0;
          last     <= 1'b1;
          state    <= ST_IDLE;
        end
        ST_EXP_MARK: begin
          mask <= expired_v;
          if (expired_v == '0) begin
            strobe   <= 1'b1;
            kind     <= KIND_NONE;
            timer_id <= '0;
            wait_us  <= '0;
            last     <= 1'b1;
            state    <= ST_IDLE;
          end else begin
            state <= ST_EXP_SCAN;
          end
        end
        ST_EXP_SCAN: begin
          if (mask[idx]) begin
            strobe    <= 1'b1;
            kind      <= KIND_EXPIRED;
            timer_id  <= id_v[idx];
            wait_us   <= '0;
            last      <= final_hit;
            mask[idx] <= 1'b0;
            cnt       <= cnt + CNT_W'(1);
            if (final_hit) begin
              state <= ST_IDLE;
            end
          end
          idx <= idx + IDX_W'(1);
        end
        ST_QRY_SCAN: begin
          if (valid_v[idx] && (!best_valid || dl_v[idx] < best_dl)) begin
            best_valid <= 1'b1;
            best_dl    <= dl_v[idx];
          end
          idx <= idx + IDX_W'(1);
          if (idx == IDX_W'(SLOTS - 1)) begin
            state <= ST_QRY_DONE;
          end
        end
        ST_QRY_DONE: begin
          strobe   <= 1'b1;
          kind     <= KIND_WAIT;
          timer_id <= '0;
          last     <= 1'b1;
          if (!best_valid) begin
            wait_us <= WAIT_W'(EMPTY_WAIT);
          end else if (best_dl <= {1'b0, now_r}) begin
            wait_us <= '0;
          end else if (diff > EMPTY_WAIT) begin
            wait_us <= WAIT_W'(EMPTY_WAIT);
          end else begin
            wait_us <= diff[WAIT_W-1:0];
          end
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // an accepted command always makes the block busy in the following cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst) accept |=> busy)
    else $error("busy not raised after accept");

  // every result closes out work that was in progress
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst) strobe |-> $past(busy))
    else $error("result without a command in progress");

  // an added timer never gets id zero
  a_add_id: assert property (@(posedge clk) disable iff (rst)
      (strobe && kind == KIND_ADDED) |-> (timer_id != '0))
    else $error("zero id handed out");

  // wait is only reported on query results
  a_wait_zero: assert property (@(posedge clk) disable iff (rst)
      (strobe && kind != KIND_WAIT) |-> (wait_us == '0))
    else $error("wait on non-query result");

endmodule

[sv/dtt_cell.sv]
// One timer cell: holds an entry, compares it, and shifts from its neighbour.
module dtt_cell (
  input  logic                     clk,
  input  logic                     rst,
  input  dtt_pkg::cell_ctrl_t      ctrl,
  input  logic                     prev_valid,
  input  logic [dtt_pkg::ID_W-1:0] prev_id,
  input  logic [dtt_pkg::DL_W-1:0] prev_deadline,
  input  logic [dtt_pkg::ID_W-1:0] new_id,
  input  logic [dtt_pkg::DL_W-1:0] new_deadline,
  input  logic [dtt_pkg::NOW_W-1:0] now,
  input  logic [dtt_pkg::ID_W-1:0] target,
  output logic                     valid,
  output logic [dtt_pkg::ID_W-1:0] id,
  output logic [dtt_pkg::DL_W-1:0] deadline,
  output logic                     expired,
  output logic                     match
);
  import dtt_pkg::*;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.load_new) begin
      valid <= 1'b1;
    end else if (ctrl.load_prev) begin
      valid <= prev_valid;
    end else if (ctrl.clr) begin
      valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (ctrl.load_new) begin
      id       <= new_id;
      deadline <= new_deadline;
    end else if (ctrl.load_prev) begin
      id       <= prev_id;
      deadline <= prev_deadline;
    end
  end

  assign expired = valid && (deadline < {1'b0, now});
  assign match   = valid && (id == target);

endmodule

[test/tb.sv]
// Self-checking testbench for the deadline timer table: directed table then random commands.
`timescale 1ns / 100ps

module tb;
  import dtt_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 2 * SLOTS + 8;
  localparam logic [WAIT_W-1:0] WAIT_CAP = WAIT_W'(EMPTY_WAIT);

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        cmd = CMD_QUERY;
  logic [MS_W-1:0]   delay_ms = '0;
  logic [ID_W-1:0]   target_id = '0;
  logic [NOW_W-1:0]  now_us = '0;
  logic              strobe;
  logic [2:0]        kind;
  logic [ID_W-1:0]   timer_id;
  logic [WAIT_W-1:0] wait_us;
  logic              last;

  typedef struct {
    logic [2:0]        kind;
    logic [ID_W-1:0]   id;
    logic [WAIT_W-1:0] wt;
    logic              lst;
  } timer_result_t;

  typedef struct {
    logic [1:0]        cmd;
    logic [MS_W-1:0]   delay;
    logic [ID_W-1:0]   target;
    logic [NOW_W-1:0]  now;
    int                rep;
    bit                typed;
    timer_result_t     res;
  } stim_row_t;

  timer_result_t pending_results[$];
  int  fail_count = 0;
  int  quiet_cycles = 0;
  int  idle_pct = 0;

  // shadow copy of the timer table
  bit               sh_valid[SLOTS];
  logic [ID_W-1:0]  sh_id[SLOTS];
  logic [DL_W-1:0]  sh_deadline[SLOTS];
  int               sh_order[SLOTS];
  logic [ID_W-1:0]  sh_next_id;
  logic [ID_W-1:0]  last_added;

  deadline_timer_table_top uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .delay_ms(delay_ms), .target_id(target_id), .now_us(now_us),
    .strobe(strobe), .kind(kind), .timer_id(timer_id), .wait_us(wait_us),
    .last(last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic timer_result_t mk(logic [2:0] k, logic [ID_W-1:0] i,
                                       logic [WAIT_W-1:0] w, logic l);
    timer_result_t r;
    r.kind = k; r.id = i; r.wt = w; r.lst = l;
    return r;
  endfunction

  // Work out the results of one command and update the shadow table
  task automatic predict_timers(input logic [1:0] c, input logic [MS_W-1:0] d,
                                input logic [ID_W-1:0] tgt,
                                input logic [NOW_W-1:0] nw, input bit typed,
                                input timer_result_t typed_res);
    int free_slot, pick, best, n;
    logic [DL_W-1:0] wt;
    timer_result_t got[$];
    free_slot = -1; pick = -1; best = -1; n = 0;
    case (c)
      CMD_ADD: begin
        for (int i = 0; i < SLOTS; i++)
          if (!sh_valid[i] && free_slot < 0) free_slot = i;
        if (free_slot < 0) begin
          got.push_back(mk(KIND_FULL, '0, '0, 1'b1));
        end else begin
          for (int i = 0; i < SLOTS; i++) if (sh_valid[i]) sh_order[i]++;
          sh_valid[free_slot] = 1'b1;
          sh_id[free_slot] = sh_next_id;
          sh_deadline[free_slot] = DL_W'(nw) + DL_W'(d) * DL_W'(US_PER_MS);
          sh_order[free_slot] = 0;
          got.push_back(mk(KIND_ADDED, sh_next_id, '0, 1'b1));
          last_added = sh_next_id;
          sh_next_id = (sh_next_id == ID_MAX) ? ID_W'(1) : sh_next_id + 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (tgt == '0) begin
          got.push_back(mk(KIND_BAD_ID, '0, '0, 1'b1));
        end else begin
          for (int i = 0; i < SLOTS; i++)
            if (sh_valid[i] && sh_id[i] == tgt) sh_valid[i] = 1'b0;
          got.push_back(mk(KIND_REMOVED, '0, '0, 1'b1));
        end
      end
      CMD_EXPIRE: begin
        // newest expired entry first, at most RESULT_CAP per command
        while (n < RESULT_CAP) begin
          pick = -1;
          for (int i = 0; i < SLOTS; i++)
            if (sh_valid[i] && sh_deadline[i] < DL_W'(nw) &&
                (pick < 0 || sh_order[i] < sh_order[pick])) pick = i;
          if (pick < 0) break;
          sh_valid[pick] = 1'b0;
          for (int i = 0; i < SLOTS; i++)
            if (sh_valid[i] && sh_order[i] > sh_order[pick]) sh_order[i]--;
          got.push_back(mk(KIND_EXPIRED, sh_id[pick], '0, 1'b0));
          n++;
        end
        if (n == 0) got.push_back(mk(KIND_NONE, '0, '0, 1'b1));
        else got[n-1].lst = 1'b1;
      end
      default: begin
        for (int i = 0; i < SLOTS; i++)
          if (sh_valid[i] && (best < 0 || sh_deadline[i] < sh_deadline[best])) best = i;
        if (best < 0) wt = EMPTY_WAIT;
        else if (sh_deadline[best] <= DL_W'(nw)) wt = '0;
        else begin
          wt = sh_deadline[best] - DL_W'(nw);
          if (wt > EMPTY_WAIT) wt = EMPTY_WAIT;
        end
        got.push_back(mk(KIND_WAIT, '0, WAIT_W'(wt), 1'b1));
      end
    endcase
    if (typed) pending_results.push_back(typed_res);
    else foreach (got[k]) pending_results.push_back(got[k]);
  endtask

  // Offer one command and hold it until the block takes it
  task automatic send_cmd(input logic [1:0] c, input logic [MS_W-1:0] d,
                          input logic [ID_W-1:0] tgt, input logic [NOW_W-1:0] nw,
                          input bit typed, input timer_result_t typed_res);
    int gap;
    if ($urandom_range(99) < idle_pct) begin
      gap = $urandom_range(20, 1);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c; delay_ms <= d; target_id <= tgt; now_us <= nw;
    do @(posedge clk); while (busy);
    predict_timers(c, d, tgt, nw, typed, typed_res);
  endtask

  // Let every outstanding result arrive before going on
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Result checker
  always @(posedge clk) begin
    timer_result_t e;
    if (!rst && strobe) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result kind %0d id %0d", $time, kind, timer_id);
        fail_count++;
      end else begin
        e = pending_results.pop_front();
        if (kind !== e.kind) begin
          $display("%0t: kind expected %0d actual %0d", $time, e.kind, kind);
          fail_count++;
        end
        if (timer_id !== e.id) begin
          $display("%0t: timer_id expected %0d actual %0d", $time, e.id, timer_id);
          fail_count++;
        end
        if (wait_us !== e.wt) begin
          $display("%0t: wait_us expected %0d actual %0d", $time, e.wt, wait_us);
          fail_count++;
        end
        if (last !== e.lst) begin
          $display("%0t: last expected %0d actual %0d", $time, e.lst, last);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no transaction
  always @(posedge clk) begin
    if (rst || strobe || (start && !busy)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    stim_row_t rows[$];
    logic [NOW_W-1:0] clock_us;
    logic [MS_W-1:0]  d;
    logic [ID_W-1:0]  tgt;
    logic [NOW_W-1:0] nw;
    logic [1:0]       c;
    int               sel;
    for (int i = 0; i < SLOTS; i++) begin
      sh_valid[i] = 1'b0; sh_id[i] = '0; sh_deadline[i] = '0; sh_order[i] = 0;
    end
    sh_next_id = ID_W'(1);
    last_added = ID_W'(1);

    // directed table: empty table, error codes, extremes, full table
    rows = '{
      '{CMD_QUERY,  '0, '0, '0, 1, 1, '{KIND_WAIT, '0, WAIT_CAP, 1'b1}},
      '{CMD_EXPIRE, '0, '0, '0, 1, 1, '{KIND_NONE, '0, '0, 1'b1}},
      '{CMD_REMOVE, '0, '0, '0, 1, 1, '{KIND_BAD_ID, '0, '0, 1'b1}},
      '{CMD_REMOVE, '0, 31'd5, '0, 1, 1, '{KIND_REMOVED, '0, '0, 1'b1}},
      '{CMD_ADD,    '0, '0, 48'd100, 1, 1, '{KIND_ADDED, 31'd1, '0, 1'b1}},
      '{CMD_ADD,    '1, '1, '1, 1, 1, '{KIND_ADDED, 31'd2, '0, 1'b1}},
      '{CMD_QUERY,  '0, '0, 48'd50, 1, 1, '{KIND_WAIT, '0, 37'd50, 1'b1}},
      '{CMD_QUERY,  '0, '0, 48'd100, 1, 1, '{KIND_WAIT, '0, '0, 1'b1}},
      '{CMD_QUERY,  '0, '0, '1, 1, 1, '{KIND_WAIT, '0, '0, 1'b1}},
      '{CMD_EXPIRE, '0, '0, 48'd100, 1, 1, '{KIND_NONE, '0, '0, 1'b1}},
      '{CMD_EXPIRE, '0, '0, 48'd101, 1, 1, '{KIND_EXPIRED, 31'd1, '0, 1'b1}},
      '{CMD_QUERY,  '0, '0, '0, 1, 1, '{KIND_WAIT, '0, WAIT_CAP, 1'b1}},
      '{CMD_ADD,    31'd1, '0, 48'd1000, 14, 0, '{'0, '0, '0, 1'b0}},
      '{CMD_ADD,    31'd7, '0, 48'd2000, 1, 0, '{'0, '0, '0, 1'b0}},
      '{CMD_ADD,    31'd7, '0, 48'd2000, 1, 1, '{KIND_FULL, '0, '0, 1'b1}},
      '{CMD_REMOVE, '0, 31'd3, '0, 1, 1, '{KIND_REMOVED, '0, '0, 1'b1}},
      '{CMD_QUERY,  '0, '0, 48'd1500, 1, 0, '{'0, '0, '0, 1'b0}},
      '{CMD_EXPIRE, '0, '0, 48'd5000, 1, 0, '{'0, '0, '0, 1'b0}},
      '{CMD_ADD,    31'd2, '0, 48'd10, 1, 0, '{'0, '0, '0, 1'b0}},
      '{CMD_EXPIRE, '0, '0, '1, 1, 0, '{'0, '0, '0, 1'b0}},
      '{CMD_EXPIRE, '0, '0, '1, 1, 1, '{KIND_NONE, '0, '0, 1'b1}}
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[r])
      for (int k = 0; k < rows[r].rep; k++)
        send_cmd(rows[r].cmd, rows[r].delay, rows[r].target, rows[r].now,
                 rows[r].typed, rows[r].res);
    wait_drained();

    // random phases: no idling, heavy idling, light idling
    clock_us = NOW_W'($urandom_range(100000));
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 0 : (ph == 1) ? 75 : 7;
      for (int n = 0; n < 29; n++) begin
        sel = $urandom_range(99);
        c = (sel < 40) ? CMD_ADD : (sel < 60) ? CMD_EXPIRE :
            (sel < 80) ? CMD_QUERY : CMD_REMOVE;
        clock_us = clock_us + NOW_W'($urandom_range(20000));
        nw = clock_us;
        if ($urandom_range(19) == 0) nw = NOW_W'({$urandom, $urandom});
        d = ($urandom_range(9) == 0) ? MS_W'($urandom) : MS_W'($urandom_range(60));
        sel = $urandom_range(9);
        tgt = (sel == 0) ? '0 : (sel < 3) ? ID_W'($urandom) :
              last_added - ID_W'($urandom_range(4));
        send_cmd(c, d, tgt, nw, 1'b0, mk('0, '0, '0, 1'b0));
      end
      // hold off until every expected result is in
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

[filelist.f]
sv/dtt_pkg.sv
sv/dtt_cell.sv
sv/deadline_timer_table_top.sv
test/tb.sv
